// ----- hdl/sdr_pkg.sv -----
// Shared constants, types and the per-channel debounce step for the switch debounce reporter.
package sdr_pkg;

   localparam int CHANNELS = 8;
   localparam int DATA_W   = 8;
   localparam int WIDE_W   = (CHANNELS > DATA_W) ? CHANNELS : DATA_W;

   typedef logic [1:0]        phase_type;
   typedef logic [DATA_W-1:0] report_type;

   localparam phase_type PHASE_IDLE     = 2'd0;
   localparam phase_type PHASE_ONE_HIGH = 2'd1;
   localparam phase_type PHASE_PRESSED  = 2'd2;
   localparam phase_type PHASE_ONE_LOW  = 2'd3;

   typedef struct packed {
      logic       emit;
      report_type report;
   } result_type;

   function automatic phase_type next_phase(input phase_type phase, input logic level);
      phase_type result;
      case (phase)
         PHASE_IDLE:     result = level ? PHASE_ONE_HIGH : PHASE_IDLE;
         PHASE_ONE_HIGH: result = level ? PHASE_PRESSED  : PHASE_IDLE;
         PHASE_PRESSED:  result = level ? PHASE_PRESSED  : PHASE_ONE_LOW;
         default:        result = level ? PHASE_PRESSED  : PHASE_IDLE;
      endcase
      return result;
   endfunction

endpackage

// ----- hdl/sdr_debounce_bank.sv -----
// Bank of per-channel debouncers with the previous-report register and the report decision.
module sdr_debounce_bank (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  sdr_pkg::report_type levels,
   input  logic               request,
   output sdr_pkg::result_type result
);
   import sdr_pkg::*;

   phase_type         phase_ff [CHANNELS];
   phase_type         phase_in [CHANNELS];
   report_type        previous_ff;
   logic [WIDE_W-1:0] level_w;
   logic [WIDE_W-1:0] bits_w;
   report_type        report_w;

   // Channels beyond the input width see a low level and so stay idle.
   assign level_w = WIDE_W'(levels);

   always_comb begin
      bits_w = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         phase_in[ch] = next_phase(phase_ff[ch], level_w[ch]);
         bits_w[ch]   = phase_in[ch][1];
      end
   end

   assign report_w      = bits_w[DATA_W-1:0];
   assign result.report = report_w;
   assign result.emit   = accept && (request || (report_w != previous_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            phase_ff[ch] <= PHASE_IDLE;
         end
         previous_ff <= '0;
      end else if (accept) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            phase_ff[ch] <= phase_in[ch];
         end
         previous_ff <= report_w;
      end
   end

endmodule

// ----- hdl/switch_debounce_reporter_core.sv -----
// Top level of the switch debounce reporter: debouncer bank feeding a two-entry result buffer.
//
//   Channel  Direction  Word contents (lowest bit first)
//   req      in         tdata[7:0] switch_levels; tuser[0] host_request
//   rsp      out        tdata[7:0] report_bits
//
// Each accepted word updates all debouncers in the same cycle; a due report goes to the result
// register, or to the skid register while rsp stalls, so a word can be taken every clock while
// the skid register is empty. The two registers hold up to two reports; req_tready falls only
// while the skid register is occupied. Reset is synchronous and returns every channel to idle.
module switch_debounce_reporter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] switch_levels
   input  logic       req_tuser,   // [0] host_request
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] report_bits
);
   import sdr_pkg::*;

   logic       accept_w;
   result_type result_w;
   logic       out_valid_ff, out_valid_in;
   report_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   report_type skid_data_ff, skid_data_in;

   assign req_tready = !skid_valid_ff;
   assign accept_w   = req_tvalid && req_tready;

   sdr_debounce_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept_w),
      .levels  (req_tdata),
      .request (req_tuser),
      .result  (result_w)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = result_w.emit;
            out_data_in  = result_w.report;
         end
      end else if (result_w.emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result_w.report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hdl/sdr_checker.sv -----
// Port-level checks on the switch debounce reporter and the bind that attaches them.
module sdr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or vanished while stalled");

   // Nothing is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output valid or input stalled after reset");

   // A host request is always followed on the next cycle by a valid result word on rsp.
   a_request_report: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> rsp_tvalid)
      else $error("host request produced no report");

   // The input only stalls while a result is waiting to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // A stall on the input lasts no longer than the output stall behind it.
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("input stayed stalled after the result was taken");

endmodule

bind switch_debounce_reporter_core sdr_checker u_sdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
